FILE: sv/lgf_pkg.sv
// Shared types and constants for the latency-gated FIFO.
// No dependencies; used by lgf_ctrl, lgf_out and latency_gated_fifo_core.
`default_nettype none

package lgf_pkg;

    localparam int OP_W  = 2;
    localparam int CFG_W = 5;
    localparam int OCC_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } op_e_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_TICK = 4'b0100,
        S_HOLD = 4'b1000
    } state_t;

    // Status part of one result; the popped word travels beside it.
    typedef struct packed {
        logic             pop_valid;
        logic             push_dropped;
        logic [OCC_W-1:0] occupancy;
        logic             is_empty;
        logic             is_full;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/lgf_mem.sv
// Entry storage: data word memory and remaining-wait memory, one shared write
// address, one registered read port. Standalone, no package needed.
`default_nettype none

module lgf_mem #(
    parameter int DEPTH         = 16,
    parameter int DATA_WIDTH    = 64,
    parameter int LATENCY_WIDTH = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       data_we,
    input  wire logic                       wait_we,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_WIDTH-1:0]      wr_data,
    input  wire logic [LATENCY_WIDTH-1:0]   wr_wait,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_WIDTH-1:0]      rd_data_reg,
    output logic      [LATENCY_WIDTH-1:0]   rd_wait_reg
);

    logic [DATA_WIDTH-1:0]    data_mem [DEPTH];
    logic [LATENCY_WIDTH-1:0] wait_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[wr_addr] <= wr_data;
        end
        if (wait_we) begin
            wait_mem[wr_addr] <= wr_wait;
        end
        if (rd_en) begin
            rd_data_reg <= data_mem[rd_addr];
            rd_wait_reg <= wait_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/lgf_ctrl.sv
// Sequencer for the latency-gated FIFO: pointers, count, tick sweep over the
// wait memory, pop read-check. Depends on lgf_pkg and drives lgf_mem.
`default_nettype none

module lgf_ctrl #(
    parameter int DEPTH         = 16,
    parameter int DATA_WIDTH    = 64,
    parameter int LATENCY_WIDTH = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire lgf_pkg::op_e_t                item_op,
    input  wire logic [DATA_WIDTH-1:0]         item_payload,
    input  wire logic [LATENCY_WIDTH-1:0]      item_latency,
    input  wire logic [$clog2(DEPTH+1)-1:0]    limit,
    // memory side
    output logic                               data_we,
    output logic                               wait_we,
    output logic      [$clog2(DEPTH)-1:0]      wr_addr,
    output logic      [DATA_WIDTH-1:0]         wr_data,
    output logic      [LATENCY_WIDTH-1:0]      wr_wait,
    output logic                               rd_en,
    output logic      [$clog2(DEPTH)-1:0]      rd_addr,
    input  wire logic [DATA_WIDTH-1:0]         rd_data,
    input  wire logic [LATENCY_WIDTH-1:0]      rd_wait,
    // result side
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output lgf_pkg::res_t                      res,
    output logic      [DATA_WIDTH-1:0]         res_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    lgf_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [CW-1:0]   left_reg, left_next;
    lgf_pkg::res_t   pend_reg, pend_next;
    logic [DATA_WIDTH-1:0] pend_data_reg, pend_data_next;

    logic                  produce;
    logic                  pop_ok;
    logic                  dropped;
    logic [DATA_WIDTH-1:0] pop_word;
    lgf_pkg::res_t         new_res;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        next_slot = (i == AW'(DEPTH-1)) ? '0 : i + 1'b1;
    endfunction

    assign item_ready = (state_reg == lgf_pkg::S_IDLE);
    assign wr_data    = item_payload;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;
        data_we        = 1'b0;
        wait_we        = 1'b0;
        wr_addr        = tail_reg;
        wr_wait        = item_latency;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        produce        = 1'b0;
        pop_ok         = 1'b0;
        dropped        = 1'b0;
        pop_word       = '0;

        case (state_reg)
            lgf_pkg::S_IDLE: begin
                if (item_valid) begin
                    case (item_op)
                        lgf_pkg::OP_PUSH: begin
                            produce = 1'b1;
                            if (count_reg >= limit) begin
                                dropped = 1'b1;
                            end else begin
                                data_we    = 1'b1;
                                wait_we    = 1'b1;
                                tail_next  = next_slot(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        lgf_pkg::OP_POP: begin
                            if (count_reg == '0) begin
                                produce = 1'b1;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = lgf_pkg::S_POP;
                            end
                        end
                        lgf_pkg::OP_TICK: begin
                            if (count_reg == '0) begin
                                produce = 1'b1;
                            end else begin
                                rd_en      = 1'b1;
                                slot_next  = head_reg;
                                left_next  = count_reg;
                                state_next = lgf_pkg::S_TICK;
                            end
                        end
                        lgf_pkg::OP_CLEAR: begin
                            produce    = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        default: begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            lgf_pkg::S_POP: begin
                produce = 1'b1;
                if (rd_wait == '0) begin
                    pop_ok     = 1'b1;
                    pop_word   = rd_data;
                    head_next  = next_slot(head_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            lgf_pkg::S_TICK: begin
                // write back the slot read last cycle, fetch the next one
                wait_we = 1'b1;
                wr_addr = slot_reg;
                wr_wait = (rd_wait != '0) ? rd_wait - 1'b1 : rd_wait;
                if (left_reg > CW'(1)) begin
                    rd_en     = 1'b1;
                    rd_addr   = next_slot(slot_reg);
                    slot_next = next_slot(slot_reg);
                    left_next = left_reg - 1'b1;
                end else begin
                    produce = 1'b1;
                end
            end
            lgf_pkg::S_HOLD: begin
                if (res_ready) begin
                    state_next = lgf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lgf_pkg::S_IDLE;
            end
        endcase

        new_res.pop_valid    = pop_ok;
        new_res.push_dropped = dropped;
        new_res.occupancy    = lgf_pkg::OCC_W'(count_next);
        new_res.is_empty     = (count_next == '0);
        new_res.is_full      = (count_next >= limit);

        if (produce) begin
            if (res_ready) begin
                state_next = lgf_pkg::S_IDLE;
            end else begin
                pend_next      = new_res;
                pend_data_next = pop_word;
                state_next     = lgf_pkg::S_HOLD;
            end
        end
    end

    always_comb begin
        if (state_reg == lgf_pkg::S_HOLD) begin
            res_valid = 1'b1;
            res       = pend_reg;
            res_data  = pend_data_reg;
        end else begin
            res_valid = produce;
            res       = new_res;
            res_data  = pop_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lgf_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        left_reg      <= left_next;
        pend_reg      <= pend_next;
        pend_data_reg <= pend_data_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        ((((CW+1)'(head_reg) + (CW+1)'(count_reg)) >= (CW+1)'(DEPTH)) ?
          (((CW+1)'(head_reg) + (CW+1)'(count_reg)) - (CW+1)'(DEPTH)) :
          ((CW+1)'(head_reg) + (CW+1)'(count_reg))) == (CW+1)'(tail_reg))
        else $error("head, count and tail disagree");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        data_we |-> (count_reg < limit))
        else $error("push written with queue full");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lgf_pkg::S_POP && rd_wait == '0)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("successful pop did not lower the count");

    a_sweep_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lgf_pkg::S_TICK) |-> (left_reg != '0 && wait_we))
        else $error("tick sweep running with nothing left");
`endif

endmodule

`default_nettype wire

FILE: sv/lgf_out.sv
// Output register for results: decouples the sequencer from master-side stalls.
// Depends on lgf_pkg (res_t).
`default_nettype none

module lgf_out #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   res_valid,
    output logic                        res_ready,
    input  wire lgf_pkg::res_t          res,
    input  wire logic [DATA_WIDTH-1:0]  res_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output lgf_pkg::res_t               m_res,
    output logic      [DATA_WIDTH-1:0]  m_data
);

    logic valid_reg, valid_next;

    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = res_ready ? res_valid : valid_reg;
    assign m_valid    = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // load a new item whenever the register is free or being drained
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res  <= res;
            m_data <= res_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/latency_gated_fifo_core.sv
// Top level of the latency-gated FIFO: capacity register, stream packing, and
// the lgf_ctrl / lgf_mem / lgf_out instances. Depends on lgf_pkg.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: operation; tdata: payload, latency
//  m_      | out | m_tvalid/m_tready  | tdata: pop_data, pop_valid, push_dropped,
//          |     |                    |        occupancy, is_empty, is_full
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data: capacity_limit
//
// Push, clear, and pop or tick on an empty queue are answered from the idle state;
// a pop first does a registered read of the head entry; a tick sweeps the wait
// memory over the occupied entries, one read-modify-write a cycle.
// Reset (aresetn low, synchronous) empties the queue and sets capacity_limit to 16;
// entry memories are not cleared. One result waits in the output register while
// the next item is taken; a further result holds s_tready low until m_tready.
`default_nettype none

module latency_gated_fifo_core #(
    parameter int DEPTH         = 16,
    parameter int DATA_WIDTH    = 64,
    parameter int LATENCY_WIDTH = 8
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // input items
    input  wire logic                                              s_tvalid,
    output logic                                                   s_tready,
    // s_tdata, from bit 0: payload, latency, zero fill
    input  wire logic [((DATA_WIDTH+LATENCY_WIDTH+7)/8)*8-1:0]     s_tdata,
    // s_tuser, from bit 0: operation
    input  wire logic [lgf_pkg::OP_W-1:0]                          s_tuser,
    // results
    output logic                                                   m_tvalid,
    input  wire logic                                              m_tready,
    // m_tdata, from bit 0: pop_data, pop_valid, push_dropped, occupancy,
    // is_empty, is_full, zero fill
    output logic      [((DATA_WIDTH+9+7)/8)*8-1:0]                 m_tdata,
    // configuration
    input  wire logic                                              cfg_wr_en,
    input  wire logic [lgf_pkg::CFG_W-1:0]                         cfg_wr_data
);

    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH+1);
    localparam int CMPW      = (CW > lgf_pkg::CFG_W) ? CW : lgf_pkg::CFG_W;
    localparam int M_TDATA_W = ((DATA_WIDTH+9+7)/8)*8;

    logic [lgf_pkg::CFG_W-1:0] cap_reg;
    logic [CMPW-1:0]           cap_ext;
    logic [CW-1:0]             limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lgf_pkg::CFG_W'(16);
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // zero acts as one, anything above the depth acts as the depth
    assign cap_ext = CMPW'(cap_reg);
    always_comb begin
        if (cap_reg == '0) begin
            limit = CW'(1);
        end else if (cap_ext > CMPW'(DEPTH)) begin
            limit = CW'(DEPTH);
        end else begin
            limit = CW'(cap_ext);
        end
    end

    logic                     data_we, wait_we, rd_en;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0]    wr_data, rd_data;
    logic [LATENCY_WIDTH-1:0] wr_wait, rd_wait;
    logic                     res_valid, res_ready;
    lgf_pkg::res_t            res, m_res;
    logic [DATA_WIDTH-1:0]    res_data, m_data;

    lgf_ctrl #(
        .DEPTH         (DEPTH),
        .DATA_WIDTH    (DATA_WIDTH),
        .LATENCY_WIDTH (LATENCY_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .item_op      (lgf_pkg::op_e_t'(s_tuser)),
        .item_payload (s_tdata[DATA_WIDTH-1:0]),
        .item_latency (s_tdata[DATA_WIDTH+LATENCY_WIDTH-1:DATA_WIDTH]),
        .limit        (limit),
        .data_we      (data_we),
        .wait_we      (wait_we),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .wr_wait      (wr_wait),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .rd_wait      (rd_wait),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .res_data     (res_data)
    );

    lgf_mem #(
        .DEPTH         (DEPTH),
        .DATA_WIDTH    (DATA_WIDTH),
        .LATENCY_WIDTH (LATENCY_WIDTH)
    ) u_mem (
        .aclk        (aclk),
        .data_we     (data_we),
        .wait_we     (wait_we),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .wr_wait     (wr_wait),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data),
        .rd_wait_reg (rd_wait)
    );

    lgf_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .res_data  (res_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res),
        .m_data    (m_data)
    );

    assign m_tdata = M_TDATA_W'({m_res.is_full, m_res.is_empty, m_res.occupancy,
                                 m_res.push_dropped, m_res.pop_valid, m_data});

endmodule

`default_nettype wire

FILE: bench/latency_gated_fifo_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for latency_gated_fifo_core: random and directed push, pop,
// tick and clear items against a built-in queue predictor. Depends on lgf_pkg.

module latency_gated_fifo_core_test;

    localparam int QUEUE_DEPTH    = 16;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int QUIET_LIMIT    = 3000;

    typedef struct {
        lgf_pkg::op_e_t op;
        logic [63:0]    payload;
        logic [7:0]     latency;
    } fifo_item_t;

    typedef struct {
        logic [63:0]   pop_data;
        lgf_pkg::res_t status;
    } fifo_result_t;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [71:0]                s_tdata     = '0;
    logic [lgf_pkg::OP_W-1:0]   s_tuser     = lgf_pkg::OP_TICK;
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [79:0]                m_tdata;
    logic                       cfg_wr_en   = 1'b0;
    logic [lgf_pkg::CFG_W-1:0]  cfg_wr_data = '0;

    latency_gated_fifo_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predicted queue contents
    logic [63:0]               slot_data [QUEUE_DEPTH];
    logic [7:0]                slot_wait [QUEUE_DEPTH];
    int unsigned               q_head  = 0;
    int unsigned               q_tail  = 0;
    int unsigned               q_count = 0;
    logic [lgf_pkg::CFG_W-1:0] capacity_reg = 5'd16;

    fifo_item_t   pending_items[$];
    fifo_result_t expected_results[$];
    fifo_item_t   cur_item;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holdoff_req    = 0;
    int unsigned holdoff_seen   = 0;
    int unsigned holdoff_left   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned error_count    = 0;

    function automatic int unsigned effective_capacity();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > QUEUE_DEPTH)
            return QUEUE_DEPTH;
        return int'(capacity_reg);
    endfunction

    function automatic fifo_result_t predict_queue_step(fifo_item_t it);
        fifo_result_t r;
        int unsigned  lim;
        int unsigned  slot;
        lim = effective_capacity();
        r.pop_data = '0;
        r.status = '0;
        case (it.op)
            lgf_pkg::OP_TICK: begin
                slot = q_head;
                for (int i = 0; i < q_count; i++) begin
                    if (slot_wait[slot] != 0)
                        slot_wait[slot] = slot_wait[slot] - 8'd1;
                    slot = (slot + 1) % QUEUE_DEPTH;
                end
            end
            lgf_pkg::OP_PUSH: begin
                if (q_count >= lim) begin
                    r.status.push_dropped = 1'b1;
                end else begin
                    slot_data[q_tail] = it.payload;
                    slot_wait[q_tail] = it.latency;
                    q_tail = (q_tail + 1) % QUEUE_DEPTH;
                    q_count++;
                end
            end
            lgf_pkg::OP_POP: begin
                if (q_count != 0 && slot_wait[q_head] == 0) begin
                    r.pop_data = slot_data[q_head];
                    r.status.pop_valid = 1'b1;
                    q_head = (q_head + 1) % QUEUE_DEPTH;
                    q_count--;
                end
            end
            default: begin
                q_head  = 0;
                q_tail  = 0;
                q_count = 0;
            end
        endcase
        r.status.occupancy = q_count[lgf_pkg::OCC_W-1:0];
        r.status.is_empty  = (q_count == 0);
        r.status.is_full   = (q_count >= lim);
        return r;
    endfunction

    // Sender: predict on acceptance, then offer the next item or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_queue_step(cur_item));
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.latency, cur_item.payload};
                    s_tuser  <= cur_item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_left != 0) begin
            m_tready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_seen != holdoff_req) begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        fifo_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding: m_tdata %0h", m_tdata);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("pop_data", e.pop_data, m_tdata[63:0]);
                check_field("pop_valid", 64'(e.status.pop_valid), 64'(m_tdata[64]));
                check_field("push_dropped", 64'(e.status.push_dropped), 64'(m_tdata[65]));
                check_field("occupancy", 64'(e.status.occupancy), 64'(m_tdata[70:66]));
                check_field("is_empty", 64'(e.status.is_empty), 64'(m_tdata[71]));
                check_field("is_full", 64'(e.status.is_full), 64'(m_tdata[72]));
            end
        end
    end

    // Watchdog: end the run if no handshake completes for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_item(lgf_pkg::op_e_t op, logic [63:0] payload, logic [7:0] latency);
        fifo_item_t it;
        it.op = op;
        it.payload = payload;
        it.latency = latency;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_capacity(logic [lgf_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        capacity_reg = value;
        @(negedge aclk);
    endtask

    // Fill-leaning mix pushes harder; drain-leaning mix pops and ticks more
    task automatic add_random_item(bit fill_bias);
        int unsigned    pick;
        int unsigned    lat_pick;
        int unsigned    data_pick;
        lgf_pkg::op_e_t op;
        logic [63:0]    payload;
        logic [7:0]     latency;
        pick      = $urandom_range(99);
        lat_pick  = $urandom_range(99);
        data_pick = $urandom_range(99);
        if (pick < (fill_bias ? 55 : 20))
            op = lgf_pkg::OP_PUSH;
        else if (pick < (fill_bias ? 75 : 50))
            op = lgf_pkg::OP_TICK;
        else if (pick < 97)
            op = lgf_pkg::OP_POP;
        else
            op = lgf_pkg::OP_CLEAR;
        if (lat_pick < 70)
            latency = 8'($urandom_range(2));
        else if (lat_pick < 94)
            latency = 8'($urandom_range(10, 3));
        else
            latency = 8'($urandom_range(255));
        if (data_pick < 5)
            payload = '0;
        else if (data_pick < 10)
            payload = '1;
        else
            payload = {$urandom, $urandom};
        add_item(op, payload, latency);
    endtask

    task automatic run_phase(logic [lgf_pkg::CFG_W-1:0] cap, int unsigned snd_pct,
                             int unsigned rcv_pct, int unsigned n_items, bit with_holdoff);
        wait_drained();
        write_capacity(cap);
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        if (with_holdoff) begin
            // Stall the output while the sender keeps pushing, so the block backs up
            holdoff_req++;
            for (int i = 0; i < n_items; i++)
                add_item(lgf_pkg::OP_PUSH, {$urandom, $urandom}, 8'($urandom_range(3)));
        end else begin
            for (int i = 0; i < n_items; i++)
                add_random_item(((i / 32) % 2) == 0);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty-queue cases, extremes, blocked head, clear
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_TICK, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_PUSH, '1, 8'h00);
        add_item(lgf_pkg::OP_PUSH, 64'h0, 8'hff);
        add_item(lgf_pkg::OP_PUSH, 64'ha5a5_5a5a_c3c3_3c3c, 8'h01);
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_TICK, '1, 8'hff);
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_CLEAR, '1, 8'hff);
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_PUSH, 64'h0123_4567_89ab_cdef, 8'h01);
        add_item(lgf_pkg::OP_PUSH, 64'hfedc_ba98_7654_3210, 8'h00);
        add_item(lgf_pkg::OP_PUSH, 64'h5555_aaaa_5555_aaaa, 8'h02);
        wait_drained();

        // Lower the limit below the occupancy: nothing is lost, pushes drop
        write_capacity(5'd2);
        add_item(lgf_pkg::OP_PUSH, 64'h1111, 8'h00);
        add_item(lgf_pkg::OP_TICK, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_PUSH, 64'h2222, 8'h00);
        add_item(lgf_pkg::OP_PUSH, 64'h3333, 8'h00);
        wait_drained();

        // A zero limit acts as one
        write_capacity(5'd0);
        add_item(lgf_pkg::OP_CLEAR, 64'h0, 8'h0);
        add_item(lgf_pkg::OP_PUSH, 64'h4444, 8'h00);
        add_item(lgf_pkg::OP_PUSH, 64'h5555, 8'h00);
        add_item(lgf_pkg::OP_POP, 64'h0, 8'h0);

        run_phase(5'd16, 0, 0, 300, 1'b0);
        run_phase(5'd5, 54, 0, 250, 1'b0);
        run_phase(5'd1, 0, 54, 200, 1'b0);
        run_phase(5'd31, 36, 36, 300, 1'b0);
        run_phase(5'd0, 36, 36, 150, 1'b0);
        run_phase(5'd8, 0, 0, 250, 1'b0);
        run_phase(5'd17, 54, 0, 250, 1'b0);
        run_phase(5'd16, 0, 0, 60, 1'b1);
        run_phase(5'd3, 36, 36, 200, 1'b0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/lgf_pkg.sv
sv/lgf_mem.sv
sv/lgf_ctrl.sv
sv/lgf_out.sv
sv/latency_gated_fifo_core.sv
bench/latency_gated_fifo_core_test.sv
